/* rtl/tzma_pkg.sv */
// ----------------------------------------------------------------------------
// tzma_pkg
// Shared types, sizes and zone geometry for the thermal zone min/max alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package tzma_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 80;
  localparam int FRAME_HEIGHT = 62;
  localparam int COL_W        = $clog2(FRAME_WIDTH);
  localparam int ROW_W        = $clog2(FRAME_HEIGHT);

  // item and result sizes
  localparam int VAL_W     = 16;
  localparam int NUM_ZONES = 9;
  localparam int ZONE_W    = 4;
  localparam int MASK_W    = NUM_ZONES + 1;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] VAL_ONES = '1;

  // zone rectangles, right and bottom edges excluded
  localparam int ZONE_X1 [NUM_ZONES] = '{ 1, 27, 53,  1, 27, 53,  1, 27, 53};
  localparam int ZONE_Y1 [NUM_ZONES] = '{ 1,  1,  1, 21, 21, 21, 41, 41, 41};
  localparam int ZONE_X2 [NUM_ZONES] = '{26, 52, 78, 26, 52, 78, 26, 52, 78};
  localparam int ZONE_Y2 [NUM_ZONES] = '{20, 20, 20, 40, 40, 40, 60, 60, 60};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_THR = 2'd0,
    REG_ZONE_LO   = 2'd1,
    REG_ZONE_HI   = 2'd2,
    REG_ZONE_NINE = 2'd3
  } cfg_reg_e;

  // result sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic [COL_W-1:0] x1;
    logic [ROW_W-1:0] y1;
    logic [COL_W-1:0] x2;
    logic [ROW_W-1:0] y2;
  } rect_t;

  // item travelling down the cell row
  typedef struct packed {
    logic             clear;
    logic             last;
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tok_t;

  // captured zone result
  typedef struct packed {
    logic [VAL_W-1:0] zmax;
    logic [VAL_W-1:0] zmin;
    logic             alarm;
  } snap_t;

endpackage

`default_nettype wire

/* rtl/tzma_cell.sv */
// ----------------------------------------------------------------------------
// tzma_cell
// One zone of the cell row: running min/max, end-of-frame capture, and a
// stage of the pixel pipeline and of the result shift chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tzma_cell
  import tzma_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  rect_t            rect_i,
  input  wire [VAL_W-1:0]  thr_i,
  input  wire              tok_valid_i,
  input  tok_t             tok_i,
  output logic             tok_valid_o,
  output tok_t             tok_o,
  input  wire              shift_i,
  input  snap_t            snap_i,
  output snap_t            snap_o
);

  logic [VAL_W-1:0] max_q, min_q;
  logic [VAL_W-1:0] upd_max, upd_min;
  logic             hit;
  logic             tok_valid_q;
  tok_t             tok_q;
  snap_t            snap_q;

  // zone membership of the incoming pixel
  assign hit = tok_valid_i && !tok_i.clear &&
               (tok_i.col >= rect_i.x1) && (tok_i.col < rect_i.x2) &&
               (tok_i.row >= rect_i.y1) && (tok_i.row < rect_i.y2);

  assign upd_max = (hit && (tok_i.value > max_q)) ? tok_i.value : max_q;
  assign upd_min = (hit && (tok_i.value < min_q)) ? tok_i.value : min_q;

  // zone store, cleared by a header or after the last pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= VAL_ONES;
    end else if (tok_valid_i) begin
      if (tok_i.clear || tok_i.last) begin
        max_q <= '0;
        min_q <= VAL_ONES;
      end else begin
        max_q <= upd_max;
        min_q <= upd_min;
      end
    end
  end

  // capture on the last pixel, shift towards the output otherwise
  always_ff @(posedge clk_i) begin
    if (tok_valid_i && tok_i.last) begin
      snap_q.zmax  <= upd_max;
      snap_q.zmin  <= upd_min;
      snap_q.alarm <= (upd_max >= thr_i);
    end else if (shift_i) begin
      snap_q <= snap_i;
    end
  end

  // pass the item on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_i;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;
  assign snap_o      = snap_q;

endmodule

`default_nettype wire

/* rtl/tzma_ctrl.sv */
// ----------------------------------------------------------------------------
// tzma_ctrl
// Result sequencer: waits for the last pixel to leave the cell row, builds
// the alarm mask and sends the ten results through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tzma_ctrl
  import tzma_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire                 done_i,
  input  wire [VAL_W-1:0]     frame_max_i,
  input  wire [VAL_W-1:0]     frame_min_i,
  input  wire [VAL_W-1:0]     frame_thr_i,
  input  wire [NUM_ZONES-1:0] alarms_i,
  input  snap_t               head_i,
  output logic                shift_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [ZONE_W-1:0]   out_zone_o,
  output logic [VAL_W-1:0]    out_zone_max_o,
  output logic [VAL_W-1:0]    out_zone_min_o,
  output logic                out_zone_alarm_o,
  output logic [MASK_W-1:0]   out_alarm_mask_o,
  output logic                out_last_o
);

  seq_state_e          state_q, state_d;
  logic [ZONE_W-1:0]   idx_q, idx_d;
  logic [VAL_W-1:0]    fmax_q, fmin_q;
  logic [MASK_W-1:0]   mask_q;
  logic                load;
  logic                idx_end;
  logic                out_valid_q, out_valid_d;
  logic [ZONE_W-1:0]   zone_q;
  logic [VAL_W-1:0]    zmax_q, zmin_q;
  logic                zalarm_q, last_q;
  logic [MASK_W-1:0]   omask_q;

  assign idx_end = (idx_q == ZONE_W'(NUM_ZONES));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_FILL;
      ST_FILL: if (done_i) state_d = ST_EMIT;
      ST_EMIT: if (load && idx_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy_o  = 1'b0;
    load    = 1'b0;
    shift_o = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_FILL: busy_o = 1'b1;
      ST_EMIT: begin
        busy_o  = 1'b1;
        load    = !out_valid_q || !out_stall_i;
        shift_o = load && (idx_q != '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (done_i) begin
      idx_d = '0;
    end else if (load) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // frame entry snapshot and alarm mask
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      fmax_q <= frame_max_i;
      fmin_q <= frame_min_i;
    end
    if (done_i) begin
      mask_q <= {alarms_i, (fmax_q >= frame_thr_i)};
    end
  end

  // output register
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      zone_q  <= idx_q;
      omask_q <= mask_q;
      last_q  <= idx_end;
      if (idx_q == '0) begin
        zmax_q   <= fmax_q;
        zmin_q   <= fmin_q;
        zalarm_q <= mask_q[0];
      end else begin
        zmax_q   <= head_i.zmax;
        zmin_q   <= head_i.zmin;
        zalarm_q <= head_i.alarm;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_zone_o       = zone_q;
  assign out_zone_max_o   = zmax_q;
  assign out_zone_min_o   = zmin_q;
  assign out_zone_alarm_o = zalarm_q;
  assign out_alarm_mask_o = omask_q;
  assign out_last_o       = last_q;

endmodule

`default_nettype wire

/* rtl/thermal_zone_minmax_alarm.sv */
// ----------------------------------------------------------------------------
// thermal_zone_minmax_alarm
// Per-zone min/max tracking of thermal frames with threshold alarms.
// ----------------------------------------------------------------------------
// Throughput: one header or pixel transfer per cycle while the input is not stalled;
//   the row of nine zone cells each take one pixel a cycle.
// The first result is shown after the last pixel transfer has passed the
//   9 cell stages, mask capture and output register; results follow one a cycle unless stalled.
// The last pixel of a frame, or a header at its place, is stalled while the previous
//   frame's last pixel is still in the cell row or its ten results still wait to drain.
// Reset: asynchronous, active low; zone stores, counters and thresholds reset.
`default_nettype none

module thermal_zone_minmax_alarm
  import tzma_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  in_func_i,
  input  wire [VAL_W-1:0]      in_value_i,
  input  wire [VAL_W-1:0]      in_header_min_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [ZONE_W-1:0]    out_zone_o,
  output logic [VAL_W-1:0]     out_zone_max_o,
  output logic [VAL_W-1:0]     out_zone_min_o,
  output logic                 out_zone_alarm_o,
  output logic [MASK_W-1:0]    out_alarm_mask_o,
  output logic                 out_last_o
);

  logic [VAL_W-1:0]     frame_thr_q, nine_thr_q;
  logic [CFG_W-1:0]     zone_lo_q, zone_hi_q;
  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     col_q;
  logic [VAL_W-1:0]     frame_max_q, frame_min_q;
  logic                 accept, at_end, busy, shift;
  logic                 tok_valid [NUM_ZONES+1];
  tok_t                 tok       [NUM_ZONES+1];
  snap_t                snap      [NUM_ZONES];
  logic [NUM_ZONES-1:0] alarms;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_thr_q <= '1;
      zone_lo_q   <= '1;
      zone_hi_q   <= '1;
      nine_thr_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_THR: frame_thr_q <= cfg_data_i[VAL_W-1:0];
        REG_ZONE_LO:   zone_lo_q   <= cfg_data_i;
        REG_ZONE_HI:   zone_hi_q   <= cfg_data_i;
        REG_ZONE_NINE: nine_thr_q  <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign at_end = (row_q == ROW_W'(FRAME_HEIGHT - 1)) &&
                  (col_q == COL_W'(FRAME_WIDTH - 1));
  assign in_stall_o = busy && at_end;
  assign accept     = in_valid_i && !in_stall_o;

  // pixel position and header values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      frame_max_q <= '0;
      frame_min_q <= '0;
    end else if (accept) begin
      if (!in_func_i) begin
        frame_max_q <= in_value_i;
        frame_min_q <= in_header_min_i;
        row_q       <= '0;
        col_q       <= '0;
      end else if (at_end) begin
        row_q <= '0;
        col_q <= '0;
      end else if (col_q == COL_W'(FRAME_WIDTH - 1)) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // item entering the cell row
  assign tok_valid[0]   = accept;
  assign tok[0].clear   = !in_func_i;
  assign tok[0].last    = in_func_i && at_end;
  assign tok[0].value   = in_value_i;
  assign tok[0].row     = row_q;
  assign tok[0].col     = col_q;

  // row of zone cells
  for (genvar k = 0; k < NUM_ZONES; k++) begin : g_cell
    rect_t            rect;
    logic [VAL_W-1:0] thr;
    snap_t            snap_in;

    assign rect.x1 = COL_W'(ZONE_X1[k]);
    assign rect.y1 = ROW_W'(ZONE_Y1[k]);
    assign rect.x2 = COL_W'(ZONE_X2[k]);
    assign rect.y2 = ROW_W'(ZONE_Y2[k]);

    if (k < 4) begin : g_lo
      assign thr = zone_lo_q[VAL_W*k +: VAL_W];
    end else if (k < 8) begin : g_hi
      assign thr = zone_hi_q[VAL_W*(k-4) +: VAL_W];
    end else begin : g_nine
      assign thr = nine_thr_q;
    end

    if (k < NUM_ZONES - 1) begin : g_link
      assign snap_in = snap[k+1];
    end else begin : g_tail
      assign snap_in = '0;
    end

    tzma_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rect_i      (rect),
      .thr_i       (thr),
      .tok_valid_i (tok_valid[k]),
      .tok_i       (tok[k]),
      .tok_valid_o (tok_valid[k+1]),
      .tok_o       (tok[k+1]),
      .shift_i     (shift),
      .snap_i      (snap_in),
      .snap_o      (snap[k])
    );

    assign alarms[k] = snap[k].alarm;
  end

  // result sequencing and output register
  tzma_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (accept && in_func_i && at_end),
    .done_i           (tok_valid[NUM_ZONES] && tok[NUM_ZONES].last),
    .frame_max_i      (frame_max_q),
    .frame_min_i      (frame_min_q),
    .frame_thr_i      (frame_thr_q),
    .alarms_i         (alarms),
    .head_i           (snap[0]),
    .shift_o          (shift),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_zone_o       (out_zone_o),
    .out_zone_max_o   (out_zone_max_o),
    .out_zone_min_o   (out_zone_min_o),
    .out_zone_alarm_o (out_zone_alarm_o),
    .out_alarm_mask_o (out_alarm_mask_o),
    .out_last_o       (out_last_o)
  );

endmodule

`default_nettype wire

/* rtl/tzma_checker.sv */
// ----------------------------------------------------------------------------
// tzma_checker
// Port-level checks on the result stream of the thermal zone min/max alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module tzma_checker
  import tzma_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wire [ZONE_W-1:0]    out_zone_o,
  input wire [VAL_W-1:0]     out_zone_max_o,
  input wire [VAL_W-1:0]     out_zone_min_o,
  input wire                 out_zone_alarm_o,
  input wire [MASK_W-1:0]    out_alarm_mask_o,
  input wire                 out_last_o
);

  // last flag marks exactly the ninth zone
  a_last_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (out_zone_o == ZONE_W'(NUM_ZONES))))
    else $error("last flag does not match zone nine");

  // zone alarm agrees with its bit in the mask
  a_alarm_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_zone_o <= ZONE_W'(NUM_ZONES)) |->
      (out_zone_alarm_o == out_alarm_mask_o[out_zone_o]))
    else $error("zone alarm differs from mask bit");

  // zones of one frame come in order with one mask
  a_zone_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=>
      !out_valid_o ||
      ((out_zone_o == $past(out_zone_o) + 1'b1) &&
       (out_alarm_mask_o == $past(out_alarm_mask_o))))
    else $error("result order or mask broken within a frame");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_zone_o) && $stable(out_zone_max_o) &&
      $stable(out_zone_min_o) && $stable(out_alarm_mask_o))
    else $error("stalled result changed");

endmodule

bind thermal_zone_minmax_alarm tzma_checker u_tzma_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_zone_o       (out_zone_o),
  .out_zone_max_o   (out_zone_max_o),
  .out_zone_min_o   (out_zone_min_o),
  .out_zone_alarm_o (out_zone_alarm_o),
  .out_alarm_mask_o (out_alarm_mask_o),
  .out_last_o       (out_last_o)
);

`default_nettype wire
